[rtl/rau_pkg.sv]
// shared constants, types and helpers for the rational arithmetic unit
package rau_pkg;

    // datapath width of the arithmetic, and width of the operand ports
    localparam int WIDTH = 32;
    localparam int IO_W  = 32;
    localparam int CNT_W = $clog2(WIDTH);

    // operation codes
    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_MUL = 2'd1;
    localparam logic [1:0] FUNC_RED = 2'd2;

    typedef logic [WIDTH-1:0]   word_t;
    typedef logic [2*WIDTH-1:0] prod_t;

    // request to the shared multiply / divide unit
    typedef struct packed {
        logic  start;
        logic  is_div;
        word_t opa;
        word_t opb;
    } md_req_t;

    // response from the shared unit: done pulses once, result holds until next start
    typedef struct packed {
        logic  done;
        prod_t result;
    } md_rsp_t;

    // magnitude of a two's complement word, as an unsigned word
    function automatic word_t mag(input word_t x);
        word_t r;
        r = x[WIDTH-1] ? (word_t'(~x) + word_t'(1)) : x;
        return r;
    endfunction

endpackage

[rtl/rau_muldiv.sv]
// shared radix-2 unsigned multiplier and restoring divider, one bit per cycle
module rau_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::md_req_t  req,
    output rau_pkg::md_rsp_t  rsp
);
    import rau_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            hi_reg, hi_next;
    word_t            lo_reg, lo_next;
    word_t            b_reg, b_next;

    logic [WIDTH:0]   sum;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;

    // one step of shift-add or shift-subtract
    always_comb
    begin
        sum   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, b_reg} : '0);
        trial = {hi_reg, lo_reg[WIDTH-1]};
        diff  = trial - {1'b0, b_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        b_next    = b_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            cnt_next  = CNT_W'(WIDTH - 1);
            hi_next   = '0;
            lo_next   = req.opa;
            b_next    = req.opb;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                // remainder stays below the divisor, so the sign bit is the borrow
                if (!diff[WIDTH])
                begin
                    hi_next = diff[WIDTH-1:0];
                    lo_next = {lo_reg[WIDTH-2:0], 1'b1};
                end
                else
                begin
                    hi_next = trial[WIDTH-1:0];
                    lo_next = {lo_reg[WIDTH-2:0], 1'b0};
                end
            end
            else
            begin
                hi_next = sum[WIDTH:1];
                lo_next = {sum[0], lo_reg[WIDTH-1:1]};
            end

            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        cnt_reg <= cnt_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        b_reg   <= b_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = {hi_reg, lo_reg};

endmodule

[rtl/rational_arith_unit.sv]
// top level of the rational arithmetic unit: sequencer, gcd steps and result register
//
// Takes one request (func, num_a/den_a, num_b/den_b) and returns one result fraction with
// status and overflow. in_ready is high only while the sequencer is idle; a finished result
// sits in an output register, so the next request can be taken while it waits. All products
// and quotients go through one shared bit-serial multiply/divide unit at one bit per cycle.
// A zero denominator, an unused code or an add with equal denominators goes straight to the
// result; multiply takes two products, add with unequal denominators three products and a
// sum; reduce is a binary gcd of subtract/shift steps, as many as the magnitudes need,
// followed by two divisions.
module rational_arith_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     func,
    input  logic signed [rau_pkg::IO_W-1:0] num_a,
    input  logic signed [rau_pkg::IO_W-1:0] den_a,
    input  logic signed [rau_pkg::IO_W-1:0] num_b,
    input  logic signed [rau_pkg::IO_W-1:0] den_b,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [rau_pkg::IO_W-1:0] num_out,
    output logic signed [rau_pkg::IO_W-1:0] den_out,
    output logic                           status,
    output logic                           overflow
);
    import rau_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_START = 11'b00000000010,
        S_MREQ  = 11'b00000000100,
        S_MWAIT = 11'b00000001000,
        S_SUM   = 11'b00000010000,
        S_GTWO  = 11'b00000100000,
        S_GODD  = 11'b00001000000,
        S_GLOOP = 11'b00010000000,
        S_DREQ  = 11'b00100000000,
        S_DWAIT = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } state_t;

    state_t           state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    logic [1:0]       func_reg, func_next;
    word_t            na_reg, na_next;
    word_t            da_reg, da_next;
    word_t            nb_reg, nb_next;
    word_t            db_reg, db_next;
    word_t            n_reg, n_next;
    word_t            d_reg, d_next;
    word_t            t_reg, t_next;
    logic             st_reg, st_next;
    logic             ovf_reg, ovf_next;
    logic [1:0]       idx_reg, idx_next;
    logic             neg_reg, neg_next;
    word_t            ga_reg, ga_next;
    word_t            gb_reg, gb_next;
    logic [CNT_W-1:0] k_reg, k_next;

    logic [IO_W-1:0]  num_out_reg, num_out_next;
    logic [IO_W-1:0]  den_out_reg, den_out_next;
    logic             status_reg, status_next;
    logic             overflow_reg, overflow_next;

    md_req_t          md_req;
    md_rsp_t          md_rsp;

    word_t            mul_x, mul_y;
    word_t            add_x, add_y, add_s;
    logic             add_ovf;
    prod_t            prod_s;
    logic             prod_fit;
    word_t            quot_s;
    logic [WIDTH:0]   gdif;
    logic             mul_last;

    rau_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // shared adder with signed wrap detect
    always_comb
    begin
        add_x   = (state_reg == S_START) ? na_reg : n_reg;
        add_y   = (state_reg == S_START) ? nb_reg : t_reg;
        add_s   = add_x + add_y;
        add_ovf = (add_x[WIDTH-1] == add_y[WIDTH-1]) && (add_s[WIDTH-1] != add_x[WIDTH-1]);
    end

    // product operand selection per step
    always_comb
    begin
        mul_x = na_reg;
        mul_y = nb_reg;
        if (func_reg == FUNC_ADD)
        begin
            unique case (idx_reg)
                2'd0:
                begin
                    mul_x = na_reg;
                    mul_y = db_reg;
                end
                2'd1:
                begin
                    mul_x = nb_reg;
                    mul_y = da_reg;
                end
                default:
                begin
                    mul_x = da_reg;
                    mul_y = db_reg;
                end
            endcase
        end
        else if (idx_reg != 2'd0)
        begin
            mul_x = da_reg;
            mul_y = db_reg;
        end
        mul_last = (func_reg == FUNC_ADD) ? (idx_reg == 2'd2) : (idx_reg == 2'd1);
    end

    // signed views of the shared unit result and the gcd difference
    always_comb
    begin
        prod_s   = neg_reg ? (prod_t'(~md_rsp.result) + prod_t'(1)) : md_rsp.result;
        prod_fit = (prod_s[2*WIDTH-1:WIDTH-1] == '0) || (prod_s[2*WIDTH-1:WIDTH-1] == '1);
        quot_s   = neg_reg ? (word_t'(~md_rsp.result[WIDTH-1:0]) + word_t'(1))
                           : md_rsp.result[WIDTH-1:0];
        gdif     = {1'b0, gb_reg} - {1'b0, ga_reg};
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        func_next      = func_reg;
        na_next        = na_reg;
        da_next        = da_reg;
        nb_next        = nb_reg;
        db_next        = db_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        t_next         = t_reg;
        st_next        = st_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        ga_next        = ga_reg;
        gb_next        = gb_reg;
        k_next         = k_reg;
        num_out_next   = num_out_reg;
        den_out_next   = den_out_reg;
        status_next    = status_reg;
        overflow_next  = overflow_reg;
        md_req.start   = 1'b0;
        md_req.is_div  = 1'b0;
        md_req.opa     = mag(mul_x);
        md_req.opb     = mag(mul_y);

        // result register drains independently of the sequencer
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    na_next    = num_a[WIDTH-1:0];
                    da_next    = den_a[WIDTH-1:0];
                    nb_next    = num_b[WIDTH-1:0];
                    db_next    = den_b[WIDTH-1:0];
                    n_next     = '0;
                    d_next     = '0;
                    st_next    = 1'b0;
                    ovf_next   = 1'b0;
                    idx_next   = 2'd0;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                priority if (func_reg == FUNC_ADD || func_reg == FUNC_MUL)
                begin
                    if (da_reg == '0 || db_reg == '0)
                    begin
                        st_next    = 1'b1;
                        state_next = S_FIN;
                    end
                    else if (func_reg == FUNC_ADD && da_reg == db_reg)
                    begin
                        n_next     = add_s;
                        d_next     = da_reg;
                        ovf_next   = add_ovf;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_MREQ;
                    end
                end
                else if (func_reg == FUNC_RED)
                begin
                    if (da_reg == '0)
                    begin
                        st_next    = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ga_next    = mag(da_reg);
                        gb_next    = mag(na_reg);
                        k_next     = '0;
                        state_next = S_GTWO;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            // issue one product of magnitudes
            S_MREQ:
            begin
                md_req.start = 1'b1;
                neg_next     = mul_x[WIDTH-1] ^ mul_y[WIDTH-1];
                state_next   = S_MWAIT;
            end

            S_MWAIT:
            begin
                if (md_rsp.done)
                begin
                    if (!prod_fit)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (idx_reg == 2'd0)
                    begin
                        n_next = prod_s[WIDTH-1:0];
                    end
                    else if (mul_last)
                    begin
                        d_next = prod_s[WIDTH-1:0];
                    end
                    else
                    begin
                        t_next = prod_s[WIDTH-1:0];
                    end
                    idx_next = idx_reg + 2'd1;
                    if (!mul_last)
                    begin
                        state_next = S_MREQ;
                    end
                    else if (func_reg == FUNC_ADD)
                    begin
                        state_next = S_SUM;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            // sum of the two wrapped cross products
            S_SUM:
            begin
                n_next = add_s;
                if (add_ovf)
                begin
                    ovf_next = 1'b1;
                end
                state_next = S_FIN;
            end

            // strip common factors of two
            S_GTWO:
            begin
                if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    k_next  = k_reg + 1'b1;
                end
                else
                begin
                    state_next = S_GODD;
                end
            end

            // make the first value odd
            S_GODD:
            begin
                if (!ga_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                end
                else
                begin
                    state_next = S_GLOOP;
                end
            end

            // binary gcd: one shift or one subtract per cycle
            S_GLOOP:
            begin
                priority if (gb_reg == '0)
                begin
                    ga_next    = ga_reg << k_reg;
                    idx_next   = 2'd0;
                    state_next = S_DREQ;
                end
                else if (!gb_reg[0])
                begin
                    gb_next = gb_reg >> 1;
                end
                else if (gdif[WIDTH])
                begin
                    ga_next = gb_reg;
                    gb_next = word_t'(~gdif[WIDTH-1:0]) + word_t'(1);
                end
                else
                begin
                    gb_next = gdif[WIDTH-1:0];
                end
            end

            // divide each magnitude by the gcd
            S_DREQ:
            begin
                md_req.start  = 1'b1;
                md_req.is_div = 1'b1;
                md_req.opa    = (idx_reg == 2'd0) ? mag(na_reg) : mag(da_reg);
                md_req.opb    = ga_reg;
                neg_next      = (idx_reg == 2'd0) ? na_reg[WIDTH-1] : da_reg[WIDTH-1];
                state_next    = S_DWAIT;
            end

            S_DWAIT:
            begin
                if (md_rsp.done)
                begin
                    if (idx_reg == 2'd0)
                    begin
                        n_next     = quot_s;
                        idx_next   = 2'd1;
                        state_next = S_DREQ;
                    end
                    else
                    begin
                        d_next     = quot_s;
                        state_next = S_FIN;
                    end
                end
            end

            // hand the result over once the output register is free
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    num_out_next   = IO_W'($signed(n_reg));
                    den_out_next   = IO_W'($signed(d_reg));
                    status_next    = st_reg;
                    overflow_next  = ovf_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and result payload
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        na_reg       <= na_next;
        da_reg       <= da_next;
        nb_reg       <= nb_next;
        db_reg       <= db_next;
        n_reg        <= n_next;
        d_reg        <= d_next;
        t_reg        <= t_next;
        st_reg       <= st_next;
        ovf_reg      <= ovf_next;
        idx_reg      <= idx_next;
        neg_reg      <= neg_next;
        ga_reg       <= ga_next;
        gb_reg       <= gb_next;
        k_reg        <= k_next;
        num_out_reg  <= num_out_next;
        den_out_reg  <= den_out_next;
        status_reg   <= status_next;
        overflow_reg <= overflow_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign num_out   = num_out_reg;
    assign den_out   = den_out_reg;
    assign status    = status_reg;
    assign overflow  = overflow_reg;

    // an error result carries a zero fraction and no overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> num_out == '0 && den_out == '0 && !overflow)
        else $error("error result with nonzero payload");

    // the shared unit only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> state_reg == S_MWAIT || state_reg == S_DWAIT)
        else $error("shared unit finished outside a wait state");

    // a division is never issued with a zero gcd
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DREQ |-> ga_reg != '0)
        else $error("division by zero gcd");

    // an accepted request closes the input straight after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input reopened straight after a request");

endmodule
